@@ sv/g7u_pkg.sv @@
// ----------------------------------------------------------------------------
// g7u_pkg
// Shared types, alphabet tables and UTF-8 helpers for the GSM 7-bit to
// UTF-8 unpacker.
// ----------------------------------------------------------------------------
package g7u_pkg;

    localparam int MAX_BYTES  = 6;
    localparam int BCNT_W     = 3;
    localparam int LIMIT_W    = 10;

    localparam logic [LIMIT_W-1:0] TEXT_LIMIT_RST = 10'd255;
    localparam logic [8:0]         INDEX_MAX      = 9'd511;
    localparam logic [6:0]         ESC_CODE       = 7'h1B;
    localparam logic [15:0]        QMARK_CP       = 16'h003F;

    // Extension table codes
    localparam logic [6:0] EXT_FORM_FEED = 7'h0A;
    localparam logic [6:0] EXT_CARET     = 7'h14;
    localparam logic [6:0] EXT_LBRACE    = 7'h28;
    localparam logic [6:0] EXT_RBRACE    = 7'h29;
    localparam logic [6:0] EXT_BSLASH    = 7'h2F;
    localparam logic [6:0] EXT_LBRACKET  = 7'h3C;
    localparam logic [6:0] EXT_TILDE     = 7'h3D;
    localparam logic [6:0] EXT_RBRACKET  = 7'h3E;
    localparam logic [6:0] EXT_VBAR      = 7'h40;
    localparam logic [6:0] EXT_EURO      = 7'h65;

    typedef struct packed {
        logic [7:0] octet;
        logic       msg_start;
        logic       last_octet;
        logic [7:0] septet_count;
        logic [7:0] skip_septets;
    } src_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } txt_beat_t;

    typedef struct packed {
        logic [6:0]         carry_bits;
        logic [2:0]         carry_count;
        logic [8:0]         septet_index;
        logic               escape_pending;
        logic [LIMIT_W-1:0] bytes_written;
        logic [7:0]         msg_septets;
        logic [7:0]         skip_count;
    } unpack_state_t;

    typedef logic [MAX_BYTES-1:0][7:0] byte_buf_t;

    typedef struct packed {
        byte_buf_t         bytes;
        logic [BCNT_W-1:0] count;
    } decode_res_t;

    typedef struct packed {
        logic        emit;
        logic [15:0] cp;
        logic [8:0]  index;
        logic        escape_pending;
    } septet_res_t;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      len;
    } utf8_seq_t;

    localparam logic [15:0] ALPHA_CP [128] = '{
        16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
        16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
        16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
        16'h03A3, 16'h0398, 16'h039E, 16'h003F, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
        16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
        16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
    };

    function automatic logic [15:0] ext_cp(input logic [6:0] code);
        logic [15:0] cp;
        begin
            case (code)
                EXT_FORM_FEED: cp = 16'h000C;
                EXT_CARET:     cp = 16'h005E;
                EXT_LBRACE:    cp = 16'h007B;
                EXT_RBRACE:    cp = 16'h007D;
                EXT_BSLASH:    cp = 16'h005C;
                EXT_LBRACKET:  cp = 16'h005B;
                EXT_TILDE:     cp = 16'h007E;
                EXT_RBRACKET:  cp = 16'h005D;
                EXT_VBAR:      cp = 16'h007C;
                EXT_EURO:      cp = 16'h20AC;
                default:       cp = QMARK_CP;
            endcase
            return cp;
        end
    endfunction

    // Unused byte slots come out zero.
    function automatic utf8_seq_t utf8_encode(input logic [15:0] cp);
        utf8_seq_t s;
        begin
            s = '0;
            if (cp <= 16'h007F)
            begin
                s.bytes[0] = cp[7:0];
                s.len      = 2'd1;
            end
            else if (cp <= 16'h07FF)
            begin
                s.bytes[0] = {3'b110, cp[10:6]};
                s.bytes[1] = {2'b10, cp[5:0]};
                s.len      = 2'd2;
            end
            else
            begin
                s.bytes[0] = {4'b1110, cp[15:12]};
                s.bytes[1] = {2'b10, cp[11:6]};
                s.bytes[2] = {2'b10, cp[5:0]};
                s.len      = 2'd3;
            end
            return s;
        end
    endfunction

endpackage

@@ sv/g7u_decode.sv @@
// ----------------------------------------------------------------------------
// g7u_decode
// Unpacks one octet into at most two septets, maps them to UTF-8 and
// computes the next unpacking state. Purely combinational.
// ----------------------------------------------------------------------------
module g7u_decode
(
    input  g7u_pkg::src_beat_t              item,
    input  g7u_pkg::unpack_state_t          state,
    input  logic [g7u_pkg::LIMIT_W-1:0]     text_limit,
    output g7u_pkg::unpack_state_t          state_next,
    output g7u_pkg::decode_res_t            res
);

    function automatic g7u_pkg::septet_res_t take_septet(
        input logic [6:0] sept,
        input logic [8:0] idx,
        input logic       esc,
        input logic [7:0] msg,
        input logic [7:0] skip
    );
        g7u_pkg::septet_res_t r;
        begin
            r.emit           = 1'b0;
            r.cp             = g7u_pkg::QMARK_CP;
            r.escape_pending = 1'b0;
            r.index          = (idx < g7u_pkg::INDEX_MAX) ? idx + 9'd1 : idx;
            if (esc)
            begin
                r.emit = 1'b1;
                r.cp   = g7u_pkg::ext_cp(sept);
            end
            else if (idx >= {1'b0, skip} && idx < {1'b0, msg})
            begin
                if (sept == g7u_pkg::ESC_CODE)
                begin
                    // trailing escape turns into '?'
                    if ({1'b0, idx} + 10'd1 < {2'b00, msg})
                        r.escape_pending = 1'b1;
                    else
                        r.emit = 1'b1;
                end
                else
                begin
                    r.emit = 1'b1;
                    r.cp   = g7u_pkg::ALPHA_CP[sept];
                end
            end
            return r;
        end
    endfunction

    g7u_pkg::unpack_state_t        cur;
    logic [13:0]                   bits;
    logic                          two;
    g7u_pkg::septet_res_t          s0;
    g7u_pkg::septet_res_t          s1;
    g7u_pkg::utf8_seq_t            q0;
    g7u_pkg::utf8_seq_t            q1;
    logic [23:0]                   q0_bytes;
    logic [2:0]                    len0;
    logic [2:0]                    len1;
    logic [2:0]                    raw_len;
    logic [g7u_pkg::LIMIT_W-1:0]   room;
    logic [47:0]                   packed_bytes;

    always_comb
    begin
        cur = state;
        if (item.msg_start)
        begin
            cur             = '0;
            cur.msg_septets = item.septet_count;
            cur.skip_count  = item.skip_septets;
        end

        bits = {7'b0, cur.carry_bits} | ({6'b0, item.octet} << cur.carry_count);
        two  = (cur.carry_count >= 3'd6);

        s0 = take_septet(bits[6:0], cur.septet_index, cur.escape_pending,
                         cur.msg_septets, cur.skip_count);
        s1 = take_septet(bits[13:7], s0.index, s0.escape_pending,
                         cur.msg_septets, cur.skip_count);
        q0 = g7u_pkg::utf8_encode(s0.cp);
        q1 = g7u_pkg::utf8_encode(s1.cp);

        len0     = s0.emit ? {1'b0, q0.len} : 3'd0;
        len1     = (two && s1.emit) ? {1'b0, q1.len} : 3'd0;
        raw_len  = len0 + len1;
        q0_bytes = s0.emit ? q0.bytes : 24'h0;

        // append the second sequence right after the first
        packed_bytes = ({24'h0, q1.bytes} << {len0, 3'b000}) | {24'h0, q0_bytes};
        res.bytes    = packed_bytes;

        room = (text_limit > cur.bytes_written) ? text_limit - cur.bytes_written
                                                : '0;
        res.count = (room < {7'b0, raw_len}) ? room[2:0] : raw_len;

        state_next               = cur;
        state_next.septet_index  = two ? s1.index : s0.index;
        state_next.escape_pending = two ? s1.escape_pending : s0.escape_pending;
        state_next.bytes_written = cur.bytes_written + {7'b0, res.count};
        if (two)
        begin
            state_next.carry_bits  = '0;
            state_next.carry_count = '0;
        end
        else
        begin
            state_next.carry_bits  = bits[13:7];
            state_next.carry_count = cur.carry_count + 3'd1;
        end
        if (item.last_octet)
        begin
            state_next.carry_bits     = '0;
            state_next.carry_count    = '0;
            state_next.escape_pending = 1'b0;
        end
    end

endmodule

@@ sv/gsm7_septet_to_utf8_core.sv @@
// ----------------------------------------------------------------------------
// gsm7_septet_to_utf8_core
// Unpacks SMS user-data octets (GSM 7-bit default alphabet) into UTF-8
// text bytes, with escape to the extension table and a per-message byte cap.
// ----------------------------------------------------------------------------
//  channel  dir  payload       beat
//  src      in   src_beat_t    one packed user-data octet with message marks
//  txt      out  txt_beat_t    one UTF-8 byte, run_last on an octet's final byte
//  cfg      in   10-bit data   text_limit write
//
//  An octet is registered on its beat and decoded into a six-byte output
//  buffer once that buffer is empty or hands over its final byte; the
//  buffer register offers its bytes, one per cycle while txt is ready, 0 to 6
//  per octet. The next octet waits in the input register meanwhile.
//  rst_n clears unpacking state and sets text_limit to 255; cfg is always ready.
//  A stalled txt holds its byte; src backs up once the input register is full.
// ----------------------------------------------------------------------------
module gsm7_septet_to_utf8_core
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            src_valid,
    output logic                            src_ready,
    input  g7u_pkg::src_beat_t              src_data,

    output logic                            txt_valid,
    input  logic                            txt_ready,
    output g7u_pkg::txt_beat_t              txt_data,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [g7u_pkg::LIMIT_W-1:0]     cfg_data
);

    logic [g7u_pkg::LIMIT_W-1:0]   text_limit_reg;
    logic                          in_valid_reg;
    g7u_pkg::src_beat_t            in_data_reg;
    g7u_pkg::unpack_state_t        state_reg;
    g7u_pkg::unpack_state_t        state_next;
    g7u_pkg::decode_res_t          dec_res;
    g7u_pkg::byte_buf_t            buf_bytes_reg;
    g7u_pkg::byte_buf_t            buf_bytes_next;
    logic [g7u_pkg::BCNT_W-1:0]    buf_cnt_reg;
    logic [g7u_pkg::BCNT_W-1:0]    buf_cnt_next;
    logic                          load;
    logic                          pop;

    g7u_decode u_decode
    (
        .item       (in_data_reg),
        .state      (state_reg),
        .text_limit (text_limit_reg),
        .state_next (state_next),
        .res        (dec_res)
    );

    assign cfg_ready = 1'b1;
    assign pop       = txt_valid && txt_ready;
    // decode only when the buffer is empty or hands over its final byte now
    assign load      = in_valid_reg &&
                       (buf_cnt_reg == '0 || (buf_cnt_reg == 3'd1 && txt_ready));
    assign src_ready = !in_valid_reg || load;

    assign txt_valid         = (buf_cnt_reg != '0);
    assign txt_data.out_byte = buf_bytes_reg[0];
    assign txt_data.run_last = (buf_cnt_reg == 3'd1);

    always_comb
    begin
        buf_cnt_next   = buf_cnt_reg;
        buf_bytes_next = buf_bytes_reg;
        if (load)
        begin
            buf_cnt_next   = dec_res.count;
            buf_bytes_next = dec_res.bytes;
        end
        else if (pop)
        begin
            // advance to the next byte
            buf_cnt_next   = buf_cnt_reg - 3'd1;
            buf_bytes_next = {8'h00, buf_bytes_reg[g7u_pkg::MAX_BYTES-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_limit_reg <= g7u_pkg::TEXT_LIMIT_RST;
            in_valid_reg   <= 1'b0;
            state_reg      <= '0;
            buf_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                text_limit_reg <= cfg_data;
            if (src_ready)
                in_valid_reg <= src_valid;
            if (load)
                state_reg <= state_next;
            buf_cnt_reg <= buf_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
            in_data_reg <= src_data;
        buf_bytes_reg <= buf_bytes_next;
    end

    // a load never overwrites bytes still owed downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!txt_valid || (pop && txt_data.run_last)))
        else $error("output buffer overwritten");

    // a byte that is not the last of its octet is followed by another
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !txt_data.run_last) |=> txt_valid)
        else $error("octet run cut short");

    // at most six bits wait between octets
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.carry_count <= 3'd6)
        else $error("carry count out of range");

endmodule
